// ===== sv/tfb_pkg.sv =====
package tfb_pkg;

   // Texture store and coordinate format.
   localparam int TEX_MEM_DEPTH = 65536;
   localparam int FRAC_BITS     = 16;
   localparam int MEM_ADDR_W    = $clog2(TEX_MEM_DEPTH);

   // Field widths.
   localparam int COORD_W      = 32;
   localparam int FACE_W       = 24;
   localparam int SIZE_W       = 9;
   localparam int AXIS_W       = 8;
   localparam int TEXEL_ADDR_W = 16;
   localparam int TEXEL_W      = 24;
   localparam int FOG_W        = 9;
   localparam int COLOR_W      = 32;
   localparam int CHAN_W       = 8;
   localparam int PROD_W       = FRAC_BITS + SIZE_W;

   // Blend arithmetic widths.
   localparam int SCALE_W = 17;
   localparam int SUM_W   = 26;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_WIDTH       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_HEIGHT      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXTURE_PRESENT = 2'd2;

   // Operation codes.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Size limits.
   localparam logic [SIZE_W-1:0] SIZE_MIN = 9'd1;
   localparam logic [SIZE_W-1:0] SIZE_MAX = 9'd256;

   // Border test on the face position, Q8.16: at or below 0.2, at or above 0.8.
   localparam logic signed [FACE_W-1:0] BORDER_LO = 24'sd13107;
   localparam logic signed [FACE_W-1:0] BORDER_HI = 24'sd52429;

   // Dimming and fog weights.
   localparam logic [FOG_W-1:0] DIM_NUM  = 9'd184;
   localparam logic [FOG_W-1:0] FULL_NUM = 9'd256;
   localparam logic [FOG_W-1:0] FOG_FULL = 9'd256;
   localparam logic [TEXEL_W-1:0] FOG_RGB = 24'hB4D2FF;

   // Fixed colours.
   localparam logic [COLOR_W-1:0] GREY  = 32'hFF808080;
   localparam logic [CHAN_W-1:0]  ALPHA = 8'hFF;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Configuration as seen by the front.
   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic              present;
   } tfb_cfg_type;

   // One classified transaction.
   typedef struct packed {
      logic                    sample;
      logic                    grey;
      logic                    wr_ok;
      logic [TEXEL_ADDR_W-1:0] wr_index;
      logic [TEXEL_W-1:0]      wr_value;
      logic [AXIS_W-1:0]       x;
      logic [AXIS_W-1:0]       y;
      logic [SIZE_W-1:0]       w;
      logic                    dim;
      logic [FOG_W-1:0]        fog;
   } tfb_entry_type;

   // Queue status.
   typedef struct packed {
      logic empty;
      logic full;
   } tfb_q_status_type;

endpackage

// ===== sv/texture_sample_fog_border_top.sv =====
// Texture sampler with wrapped coordinates, border dimming and linear fog.
// Request channel (req_*): a transaction is taken at a rising edge with req_valid high
// and req_stall low. Operation zero stores req_texel_value at req_texel_index and
// gives no response; operation one samples the texture at req_coord_u/req_coord_v
// and gives one response carrying rsp_color (0xFFRRGGBB).
// Response channel (rsp_*): a response is taken when rsp_valid is high and rsp_stall
// low. Configuration (csr_*): tex_width, tex_height and texture_present are written
// at an edge with csr_we high; write them only while no transaction is in flight.
// Throughput is one transaction per cycle while rsp_stall is low. A front stage wraps
// and scales the coordinates, a four-entry queue decouples it from a back pipeline
// that forms the texel address, reads the texture memory through its single
// registered port and blends in two multiply stages before the output register.
// Reset clears the queue, the pipeline valids and the configuration (size 1 by 1,
// no texture); texture memory is not cleared and holds nothing until written.
// When rsp_stall holds a response, the back pipeline stops, the queue fills and
// req_stall rises once it is full; no transaction is lost or repeated.
module texture_sample_fog_border_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [tfb_pkg::TEXEL_ADDR_W-1:0]      req_texel_index,
   input  logic [tfb_pkg::TEXEL_W-1:0]           req_texel_value,
   input  logic signed [tfb_pkg::COORD_W-1:0]    req_coord_u,
   input  logic signed [tfb_pkg::COORD_W-1:0]    req_coord_v,
   input  logic signed [tfb_pkg::FACE_W-1:0]     req_face_u,
   input  logic signed [tfb_pkg::FACE_W-1:0]     req_face_v,
   input  logic [tfb_pkg::FOG_W-1:0]             req_fog_amount,
   input  logic                                  req_border_enable,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tfb_pkg::COLOR_W-1:0]           rsp_color,
   input  logic                                  csr_we,
   input  logic [tfb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tfb_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   tfb_pkg::tfb_cfg_type       cfg_ff;
   tfb_pkg::tfb_cfg_type       cfg_in;
   tfb_pkg::tfb_entry_type     push_entry;
   tfb_pkg::tfb_entry_type     head;
   tfb_pkg::tfb_q_status_type  q_status;
   logic                       push;
   logic                       pop;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tfb_pkg::CSR_TEX_WIDTH:       cfg_in.width   = csr_wdata;
            tfb_pkg::CSR_TEX_HEIGHT:      cfg_in.height  = csr_wdata;
            tfb_pkg::CSR_TEXTURE_PRESENT: cfg_in.present = csr_wdata[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width   <= tfb_pkg::SIZE_MIN;
         cfg_ff.height  <= tfb_pkg::SIZE_MIN;
         cfg_ff.present <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept and classify.
   tfb_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_texel_index   (req_texel_index),
      .req_texel_value   (req_texel_value),
      .req_coord_u       (req_coord_u),
      .req_coord_v       (req_coord_v),
      .req_face_u        (req_face_u),
      .req_face_v        (req_face_v),
      .req_fog_amount    (req_fog_amount),
      .req_border_enable (req_border_enable),
      .cfg               (cfg_ff),
      .q_status          (q_status),
      .push              (push),
      .entry             (push_entry)
   );

   // Queue between front and back.
   tfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // Back: memory access and blending.
   tfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_color (rsp_color)
   );

endmodule

// ===== sv/tfb_front.sv =====
module tfb_front (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [tfb_pkg::TEXEL_ADDR_W-1:0]      req_texel_index,
   input  logic [tfb_pkg::TEXEL_W-1:0]           req_texel_value,
   input  logic signed [tfb_pkg::COORD_W-1:0]    req_coord_u,
   input  logic signed [tfb_pkg::COORD_W-1:0]    req_coord_v,
   input  logic signed [tfb_pkg::FACE_W-1:0]     req_face_u,
   input  logic signed [tfb_pkg::FACE_W-1:0]     req_face_v,
   input  logic [tfb_pkg::FOG_W-1:0]             req_fog_amount,
   input  logic                                  req_border_enable,
   input  tfb_pkg::tfb_cfg_type                  cfg,
   input  tfb_pkg::tfb_q_status_type             q_status,
   output logic                                  push,
   output tfb_pkg::tfb_entry_type                entry
);

   logic [tfb_pkg::SIZE_W-1:0]    w_clamped;
   logic [tfb_pkg::SIZE_W-1:0]    h_clamped;
   logic [tfb_pkg::FRAC_BITS-1:0] frac_u;
   logic [tfb_pkg::FRAC_BITS-1:0] frac_v;
   logic [tfb_pkg::PROD_W-1:0]    prod_u;
   logic [tfb_pkg::PROD_W-1:0]    prod_v;
   logic                          in_border;

   // A transaction is taken whenever the queue has room.
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Texture size clamped to the meaningful range.
   always_comb begin
      if (cfg.width == '0) begin
         w_clamped = tfb_pkg::SIZE_MIN;
      end else if (cfg.width > tfb_pkg::SIZE_MAX) begin
         w_clamped = tfb_pkg::SIZE_MAX;
      end else begin
         w_clamped = cfg.width;
      end
      if (cfg.height == '0) begin
         h_clamped = tfb_pkg::SIZE_MIN;
      end else if (cfg.height > tfb_pkg::SIZE_MAX) begin
         h_clamped = tfb_pkg::SIZE_MAX;
      end else begin
         h_clamped = cfg.height;
      end
   end

   // Wrap the coordinates to their fraction and scale to texel columns and rows.
   assign frac_u = req_coord_u[tfb_pkg::FRAC_BITS-1:0];
   assign frac_v = req_coord_v[tfb_pkg::FRAC_BITS-1:0];
   assign prod_u = tfb_pkg::PROD_W'(frac_u) * tfb_pkg::PROD_W'(w_clamped);
   assign prod_v = tfb_pkg::PROD_W'(frac_v) * tfb_pkg::PROD_W'(h_clamped);

   // Face positions near either edge are dimmed when req_border_enable is high.
   assign in_border = (req_face_u <= tfb_pkg::BORDER_LO) || (req_face_u >= tfb_pkg::BORDER_HI) ||
                      (req_face_v <= tfb_pkg::BORDER_LO) || (req_face_v >= tfb_pkg::BORDER_HI);

   // Build the classified entry.
   always_comb begin
      entry.sample   = (req_operation == tfb_pkg::OP_SAMPLE);
      entry.grey     = !cfg.present;
      entry.wr_ok    = 32'(req_texel_index) < tfb_pkg::TEX_MEM_DEPTH;
      entry.wr_index = req_texel_index;
      entry.wr_value = req_texel_value;
      entry.x        = prod_u[tfb_pkg::FRAC_BITS+tfb_pkg::AXIS_W-1:tfb_pkg::FRAC_BITS];
      entry.y        = prod_v[tfb_pkg::FRAC_BITS+tfb_pkg::AXIS_W-1:tfb_pkg::FRAC_BITS];
      entry.w        = w_clamped;
      entry.dim      = req_border_enable && in_border;
      if (req_fog_amount > tfb_pkg::FOG_FULL) begin
         entry.fog = tfb_pkg::FOG_FULL;
      end else begin
         entry.fog = req_fog_amount;
      end
   end

endmodule

// ===== sv/tfb_queue.sv =====
module tfb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tfb_pkg::tfb_entry_type     push_entry,
   input  logic                       pop,
   output tfb_pkg::tfb_entry_type     head,
   output tfb_pkg::tfb_q_status_type  status
);

   tfb_pkg::tfb_entry_type          slot_ff [tfb_pkg::QUEUE_DEPTH];
   logic [tfb_pkg::QPTR_W-1:0]      wr_ptr_ff;
   logic [tfb_pkg::QPTR_W-1:0]      wr_ptr_in;
   logic [tfb_pkg::QPTR_W-1:0]      rd_ptr_ff;
   logic [tfb_pkg::QPTR_W-1:0]      rd_ptr_in;
   logic [tfb_pkg::QCOUNT_W-1:0]    count_ff;
   logic [tfb_pkg::QCOUNT_W-1:0]    count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == tfb_pkg::QCOUNT_W'(tfb_pkg::QUEUE_DEPTH));
   assign head         = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tfb_pkg::QPTR_W'(tfb_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tfb_pkg::QPTR_W'(tfb_pkg::QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tfb_pkg::QCOUNT_W'(tfb_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   // Nothing is taken from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");

   // A push without a pop leaves the queue holding something.
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !status.empty)
      else $error("queue empty after push");

endmodule

// ===== sv/tfb_back.sv =====
module tfb_back (
   input  logic                               clock,
   input  logic                               reset,
   input  tfb_pkg::tfb_entry_type             head,
   input  tfb_pkg::tfb_q_status_type          q_status,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tfb_pkg::COLOR_W-1:0]        rsp_color
);

   logic [tfb_pkg::TEXEL_W-1:0] tex_mem [tfb_pkg::TEX_MEM_DEPTH];

   logic                              adv;
   logic [tfb_pkg::TEXEL_ADDR_W-1:0]  row_base;
   logic [tfb_pkg::TEXEL_ADDR_W-1:0]  addr_in;
   logic                              rd_ok_in;

   // Address stage.
   logic                              s1_valid_ff;
   tfb_pkg::tfb_entry_type            s1_entry_ff;
   logic [tfb_pkg::TEXEL_ADDR_W-1:0]  s1_addr_ff;
   logic                              s1_rd_ok_ff;

   // Memory read stage.
   logic                              s2_valid_ff;
   logic                              s2_valid_in;
   logic [tfb_pkg::TEXEL_W-1:0]       s2_rdata_ff;
   logic                              s2_rd_ok_ff;
   logic                              s2_dim_ff;
   logic [tfb_pkg::FOG_W-1:0]         s2_fog_ff;
   logic                              s2_grey_ff;

   // Scale stage.
   logic [tfb_pkg::TEXEL_W-1:0]       texel;
   logic [tfb_pkg::FOG_W-1:0]         dim_factor;
   logic [tfb_pkg::SCALE_W-1:0]       cd_in [3];
   logic [tfb_pkg::SCALE_W-1:0]       kf_in [3];
   logic                              s3_valid_ff;
   logic [tfb_pkg::SCALE_W-1:0]       s3_cd_ff [3];
   logic [tfb_pkg::SCALE_W-1:0]       s3_kf_ff [3];
   logic [tfb_pkg::FOG_W-1:0]         s3_inv_fog_ff;
   logic                              s3_grey_ff;

   // Output register.
   logic [tfb_pkg::SUM_W-1:0]         sum [3];
   logic [tfb_pkg::COLOR_W-1:0]       color_in;
   logic                              out_valid_ff;
   logic [tfb_pkg::COLOR_W-1:0]       color_ff;

   // The whole back moves unless a finished result is held by the receiver.
   assign adv       = !(out_valid_ff && rsp_stall);
   assign pop       = adv && !q_status.empty;
   assign rsp_valid = out_valid_ff;
   assign rsp_color = color_ff;

   // Row-major texel address of a sample.
   assign row_base = tfb_pkg::TEXEL_ADDR_W'(head.y) * tfb_pkg::TEXEL_ADDR_W'(head.w);
   assign addr_in  = row_base + tfb_pkg::TEXEL_ADDR_W'(head.x);
   assign rd_ok_in = 32'(addr_in) < tfb_pkg::TEX_MEM_DEPTH;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= !q_status.empty;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // Only samples go on past the memory.
   assign s2_valid_in = s1_valid_ff && s1_entry_ff.sample;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_entry_ff <= head;
         s1_addr_ff  <= addr_in;
         s1_rd_ok_ff <= rd_ok_in;
         s2_rd_ok_ff <= s1_rd_ok_ff;
         s2_dim_ff   <= s1_entry_ff.dim;
         s2_fog_ff   <= s1_entry_ff.fog;
         s2_grey_ff  <= s1_entry_ff.grey;
      end
   end

   // Texture memory: one write or one registered read per transaction, in order.
   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         if (!s1_entry_ff.sample && s1_entry_ff.wr_ok) begin
            tex_mem[tfb_pkg::MEM_ADDR_W'(s1_entry_ff.wr_index)] <= s1_entry_ff.wr_value;
         end
         if (s1_entry_ff.sample) begin
            s2_rdata_ff <= tex_mem[tfb_pkg::MEM_ADDR_W'(s1_addr_ff)];
         end
      end
   end

   // Dimmed texel channels and fog terms.
   assign texel      = s2_rd_ok_ff ? s2_rdata_ff : '0;
   assign dim_factor = s2_dim_ff ? tfb_pkg::DIM_NUM : tfb_pkg::FULL_NUM;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cd_in[i] = tfb_pkg::SCALE_W'(texel[tfb_pkg::CHAN_W*(2-i) +: tfb_pkg::CHAN_W]) *
                    tfb_pkg::SCALE_W'(dim_factor);
         kf_in[i] = tfb_pkg::SCALE_W'(tfb_pkg::FOG_RGB[tfb_pkg::CHAN_W*(2-i) +: tfb_pkg::CHAN_W]) *
                    tfb_pkg::SCALE_W'(s2_fog_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s3_cd_ff[i] <= cd_in[i];
            s3_kf_ff[i] <= kf_in[i];
         end
         s3_inv_fog_ff <= tfb_pkg::FOG_FULL - s2_fog_ff;
         s3_grey_ff    <= s2_grey_ff;
      end
   end

   // Blend toward the fog colour and truncate.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = tfb_pkg::SUM_W'(s3_cd_ff[i]) * tfb_pkg::SUM_W'(s3_inv_fog_ff) +
                  (tfb_pkg::SUM_W'(s3_kf_ff[i]) << 8);
      end
      if (s3_grey_ff) begin
         color_in = tfb_pkg::GREY;
      end else begin
         color_in = {tfb_pkg::ALPHA, sum[0][23:16], sum[1][23:16], sum[2][23:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         color_ff <= color_in;
      end
   end

   // A held result freezes the stages behind it.
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s1_valid_ff) && $stable(s2_valid_ff) && $stable(s3_valid_ff))
      else $error("back pipeline moved while stalled");

   // A write never reaches the result stages.
   a_write_drops: assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff && !s1_entry_ff.sample |=> !s2_valid_ff)
      else $error("write transaction produced a result");

   // Every pop while the back moves fills the address stage.
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> s1_valid_ff)
      else $error("popped entry lost");

endmodule
